// ===== rtl/pflru_pkg.sv =====
package pflru_pkg;

  localparam int unsigned FramesDef     = 256;
  localparam int unsigned EvictBatchDef = 64;

  localparam int unsigned TagW    = 32;
  localparam int unsigned FrameW  = 8;
  localparam int unsigned EvictW  = 7;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [0:0] {
    OP_GET    = 1'b0,
    OP_CREATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_CREATED = 2'd2,
    ST_PRESENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_HRD,
    S_HUL,
    S_ERD,
    S_EUL,
    S_ARD,
    S_AWR,
    S_PUSH,
    S_DONE
  } state_e;

endpackage

// ===== rtl/page_frame_lru_directory.sv =====
// Page frame directory with LRU replacement. Each transfer on the slave side
// is a request (get or create) for one page; exactly one result transfer
// follows. Tags, LRU links and the free ring sit in single-port-read
// synchronous memories. A lookup scans the tag memory one frame per cycle,
// so a scan visits every frame at most once; a get hit then reads, unlinks
// and re-pushes the frame, an allocation reads the free ring and pushes the
// new frame, and a batch eviction reads and unlinks each evicted frame. After
// reset the free ring is filled in one pass before any request is taken.
module page_frame_lru_directory
  import pflru_pkg::*;
#(
  parameter int unsigned FRAMES      = FramesDef,
  parameter int unsigned EVICT_BATCH = EvictBatchDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [0] opcode
  input  logic [0:0]          s_axis_tuser_i,
  // [31:0] space_number, [63:32] page_number
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] status, [9:2] frame, [16:10] evicted_count
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned NW = $clog2(EVICT_BATCH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(FRAMES - 1);
  localparam logic [CW-1:0] FramesC = CW'(FRAMES);
  localparam logic [NW:0]   BatchC  = (NW+1)'(EVICT_BATCH);

  // memories
  logic [2*TagW-1:0] tag_mem  [FRAMES];
  logic [AW-1:0]     next_mem [FRAMES];
  logic [AW-1:0]     prev_mem [FRAMES];
  logic [AW-1:0]     free_mem [FRAMES];

  logic [2*TagW-1:0] tag_rd;
  logic [AW-1:0]     next_rd, prev_rd, free_rd;
  logic [AW-1:0]     tag_ra, link_ra;
  logic              tag_we;
  logic [AW-1:0]     tag_wa;
  logic              next_we, prev_we, free_we;
  logic [AW-1:0]     next_wa, prev_wa, free_wa;
  logic [AW-1:0]     next_wd, prev_wd, free_wd;

  state_e            state_q, state_d;
  logic              op_q, op_d;
  logic [TagW-1:0]   sp_q, sp_d, pg_q, pg_d;
  logic [AW-1:0]     scan_q, scan_d;
  logic              cmp_v_q, cmp_v_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]     fr_q, fr_d;
  logic              miss_q, miss_d;
  status_e           status_q, status_d;
  logic [NW-1:0]     evn_q, evn_d;
  logic [FRAMES-1:0] in_lru_q, in_lru_d;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     lru_cnt_q, lru_cnt_d;
  logic [AW-1:0]     free_head_q, free_head_d;
  logic [CW-1:0]     free_cnt_q, free_cnt_d;
  logic [AW-1:0]     init_q, init_d;
  logic              out_v_q, out_v_d;
  logic [OutDataW-1:0] out_q, out_d;

  logic              tag_hit;
  logic [AW-1:0]     ul_f;
  logic [CW-1:0]     free_pos_sum;
  logic [AW-1:0]     free_pos;
  logic [FrameW+AW-1:0] fr_ext;
  logic [EvictW+NW-1:0] ev_ext;

  assign tag_hit = cmp_v_q && in_lru_q[cmp_idx_q] && (tag_rd == {pg_q, sp_q});
  assign ul_f    = (state_q == S_HUL) ? fr_q : tail_q;
  assign free_pos_sum = CW'(free_head_q) + free_cnt_q;
  assign free_pos = (free_pos_sum >= FramesC) ? AW'(free_pos_sum - FramesC)
                                              : AW'(free_pos_sum);
  assign fr_ext = {{FrameW{1'b0}}, fr_q};
  assign ev_ext = {{EvictW{1'b0}}, evn_q};

  assign tag_ra  = scan_q;
  assign link_ra = (state_q == S_HRD) ? fr_q : tail_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: if (init_q == LastIdx) state_d = S_IDLE;
      S_IDLE: if (s_axis_tvalid_i) state_d = S_SCAN;
      S_SCAN: begin
        if (tag_hit) begin
          state_d = (op_q == OP_GET) ? S_HRD : S_DONE;
        end else if (cmp_v_q && cmp_idx_q == LastIdx) begin
          state_d = (free_cnt_q == '0) ? S_ERD : S_ARD;
        end
      end
      S_HRD:  state_d = S_HUL;
      S_HUL:  state_d = S_PUSH;
      S_ERD:  state_d = S_EUL;
      S_EUL: begin
        if ((NW+1)'(evn_q) + 1'b1 < BatchC && lru_cnt_q > CW'(1)) state_d = S_ERD;
        else state_d = S_ARD;
      end
      S_ARD:  state_d = S_AWR;
      S_AWR:  state_d = S_PUSH;
      S_PUSH: state_d = S_DONE;
      S_DONE: if (!out_v_q || m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_d = op_q; sp_d = sp_q; pg_d = pg_q;
    scan_d = scan_q; cmp_v_d = cmp_v_q; cmp_idx_d = cmp_idx_q;
    fr_d = fr_q; miss_d = miss_q; status_d = status_q; evn_d = evn_q;
    in_lru_d = in_lru_q; head_d = head_q; tail_d = tail_q; lru_cnt_d = lru_cnt_q;
    free_head_d = free_head_q; free_cnt_d = free_cnt_q; init_d = init_q;
    out_v_d = out_v_q; out_d = out_q;
    tag_we = 1'b0; tag_wa = fr_q;
    next_we = 1'b0; next_wa = fr_q; next_wd = head_q;
    prev_we = 1'b0; prev_wa = head_q; prev_wd = fr_q;
    free_we = 1'b0; free_wa = init_q; free_wd = init_q;

    if (out_v_q && m_axis_tready_i) out_v_d = 1'b0;

    case (state_q)
      S_INIT: begin
        free_we = 1'b1;
        init_d  = init_q + 1'b1;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = s_axis_tuser_i[0];
          sp_d    = s_axis_tdata_i[TagW-1:0];
          pg_d    = s_axis_tdata_i[2*TagW-1:TagW];
          scan_d  = '0;
          cmp_v_d = 1'b0;
          evn_d   = '0;
          miss_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (tag_hit) begin
          if (op_q == OP_GET) begin
            fr_d = cmp_idx_q; status_d = ST_HIT;
          end else begin
            fr_d = '0; status_d = ST_PRESENT;
          end
        end else if (cmp_v_q && cmp_idx_q == LastIdx) begin
          miss_d   = 1'b1;
          status_d = (op_q == OP_GET) ? ST_MISS : ST_CREATED;
        end else begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_q;
          scan_d    = scan_q + 1'b1;
        end
      end
      S_HUL, S_EUL: begin
        // unlink ul_f using links read in the previous cycle
        if (ul_f == head_q) head_d = next_rd;
        else begin
          next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
        end
        if (ul_f == tail_q) tail_d = prev_rd;
        else begin
          prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
        end
        if (lru_cnt_q != '0) lru_cnt_d = lru_cnt_q - 1'b1;
        if (state_q == S_EUL) begin
          in_lru_d[ul_f] = 1'b0;
          if (free_cnt_q < FramesC) begin
            free_we = 1'b1; free_wa = free_pos; free_wd = ul_f;
            free_cnt_d = free_cnt_q + 1'b1;
          end
          evn_d = evn_q + 1'b1;
        end
      end
      S_AWR: begin
        fr_d        = free_rd;
        free_head_d = (free_head_q == LastIdx) ? '0 : free_head_q + 1'b1;
        if (free_cnt_q != '0) free_cnt_d = free_cnt_q - 1'b1;
      end
      S_PUSH: begin
        if (lru_cnt_q == '0) begin
          head_d = fr_q; tail_d = fr_q;
        end else begin
          next_we = 1'b1; next_wa = fr_q; next_wd = head_q;
          prev_we = 1'b1; prev_wa = head_q; prev_wd = fr_q;
          head_d  = fr_q;
        end
        lru_cnt_d = lru_cnt_q + 1'b1;
        if (miss_q) begin
          tag_we = 1'b1;
          in_lru_d[fr_q] = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_v_q || m_axis_tready_i) begin
          out_v_d = 1'b1;
          out_d   = {7'b0, ev_ext[EvictW-1:0], fr_ext[FrameW-1:0], status_q};
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= {pg_q, sp_q};
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (free_we) free_mem[free_wa] <= free_wd;
    tag_rd  <= tag_mem[tag_ra];
    next_rd <= next_mem[link_ra];
    prev_rd <= prev_mem[link_ra];
    free_rd <= free_mem[free_head_q];
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; sp_q <= sp_d; pg_q <= pg_d;
    cmp_idx_q <= cmp_idx_d; fr_q <= fr_d; status_q <= status_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      miss_q      <= 1'b0;
      evn_q       <= '0;
      in_lru_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      lru_cnt_q   <= '0;
      free_head_q <= '0;
      free_cnt_q  <= FramesC;
      init_q      <= '0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      cmp_v_q     <= cmp_v_d;
      miss_q      <= miss_d;
      evn_q       <= evn_d;
      in_lru_q    <= in_lru_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      lru_cnt_q   <= lru_cnt_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      init_q      <= init_d;
      out_v_q     <= out_v_d;
    end
  end

`ifndef SYNTH
  a_free_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= FramesC) else $error("free count above frame count");

  a_lru_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lru_cnt_q <= FramesC) else $error("lru count above frame count");

  a_alloc_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AWR |-> free_cnt_q != '0) else $error("allocation from empty free ring");

  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NW+1)'(evn_q) <= BatchC) else $error("eviction batch overrun");
`endif

endmodule
